// ===== src/s19da_pkg.sv =====
package s19da_pkg;

    localparam int TAPS  = 19;
    localparam int TAP_W = 5;

    // request codes
    localparam logic [1:0] REQ_WRITE_VOLTAGE = 2'd0;
    localparam logic [1:0] REQ_WRITE_WEIGHT  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE       = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SCALE = 2'd0;
    localparam logic [1:0] CFG_NY    = 2'd1;
    localparam logic [1:0] CFG_NZ    = 2'd2;

    localparam logic signed [31:0] SCALE_RESET = 32'sd65536;
    localparam logic [6:0]         NY_RESET    = 7'd16;
    localparam logic [6:0]         NZ_RESET    = 7'd16;

    // per-axis step of a tap
    localparam logic [1:0] STEP_Z = 2'b00;
    localparam logic [1:0] STEP_P = 2'b01;
    localparam logic [1:0] STEP_M = 2'b11;

    localparam logic [1:0] TAP_DX [TAPS] = '{
        STEP_Z, STEP_M, STEP_Z, STEP_P, STEP_Z, STEP_Z, STEP_Z, STEP_M, STEP_P, STEP_P,
        STEP_M, STEP_M, STEP_Z, STEP_P, STEP_Z, STEP_M, STEP_Z, STEP_P, STEP_Z
    };
    localparam logic [1:0] TAP_DY [TAPS] = '{
        STEP_Z, STEP_Z, STEP_M, STEP_Z, STEP_P, STEP_Z, STEP_Z, STEP_M, STEP_M, STEP_P,
        STEP_P, STEP_Z, STEP_M, STEP_Z, STEP_P, STEP_Z, STEP_M, STEP_Z, STEP_P
    };
    localparam logic [1:0] TAP_DZ [TAPS] = '{
        STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_M, STEP_P, STEP_Z, STEP_Z, STEP_Z,
        STEP_Z, STEP_M, STEP_M, STEP_M, STEP_M, STEP_P, STEP_P, STEP_P, STEP_P
    };

    typedef struct packed {
        logic [1:0]         req_type;
        logic [11:0]        cell_index;
        logic [4:0]         tap;
        logic signed [31:0] value;
    } s19da_req_t;

    typedef struct packed {
        logic signed [31:0] derivative;
        logic               range_error;
    } s19da_res_t;

endpackage

// ===== src/s19da_ram.sv =====
module s19da_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/stencil19_diffusion_apply_top.sv =====
// channel   signals                          word          accepted when
// request   req_valid, req_stall, req_data   s19da_req_t   req_valid && !req_stall
// result    res_valid, res_stall, res_data   s19da_res_t   res_valid && !res_stall
// config    cfg_we, cfg_index, cfg_data      32-bit data   cfg_we
//
// a write request is done when accepted; a compute on a valid cell runs from acceptance
// to the result register as 19 tap reads through the shared multiply-accumulate,
// S_DRAIN1, S_DRAIN2, then S_MAG, S_MLO, S_MHI and S_SUM for magnitude, partial products
// and sum of the final scaling, then S_FIN to round, saturate and load the result register
// after reset the voltage grid is swept to zero, one cell a cycle, and no request
// is taken until the sweep ends; config writes are taken throughout
// a stalled result waits in the output register; writes are still taken meanwhile
module stencil19_diffusion_apply_top
    import s19da_pkg::*;
#(
    parameter int GRID_CELLS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  s19da_req_t  req_data,
    output logic        res_valid,
    input  logic        res_stall,
    output s19da_res_t  res_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int VAW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int WDEPTH = GRID_CELLS * TAPS;
    localparam int WAW = $clog2(WDEPTH);
    localparam int NBW = ((VAW > 15) ? VAW : 15) + 2;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_READ   = 10'b0000000100,
        S_DRAIN1 = 10'b0000001000,
        S_DRAIN2 = 10'b0000010000,
        S_MAG    = 10'b0000100000,
        S_MLO    = 10'b0001000000,
        S_MHI    = 10'b0010000000,
        S_SUM    = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] scale_reg;
    logic [6:0]         ny_reg, nz_reg;
    logic [13:0]        plane_reg;

    logic [VAW-1:0]   clr_cnt_reg;
    logic [TAP_W-1:0] tap_cnt_reg;
    logic             s1_valid_reg, s2_valid_reg;
    logic             res_valid_reg, res_valid_next;
    s19da_res_t       res_reg;

    logic [11:0]        cell_reg;
    logic [WAW-1:0]     waddr_reg;
    logic               bad_reg;
    logic               err_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        m_reg;
    logic [31:0]        s_reg;
    logic               neg_reg;
    logic [63:0]        lo_reg;
    logic [63:0]        q_reg;
    logic               rnz_reg;

    logic req_acc, cell_ok, tap_ok, start, res_load;
    logic [31:0] wbase_w;
    logic [WAW-1:0] wbase;

    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign cell_ok   = 32'(req_data.cell_index) < 32'(GRID_CELLS);
    assign tap_ok    = 32'(req_data.tap) < 32'(TAPS);
    assign start     = req_acc && (req_data.req_type == REQ_COMPUTE);

    // cell * 19 as shifts and adds
    assign wbase_w = (32'(req_data.cell_index) << 4) + (32'(req_data.cell_index) << 1)
                   + 32'(req_data.cell_index);
    assign wbase = WAW'(wbase_w);

    // neighbour index of the current tap
    logic [1:0] dx, dy, dz;
    logic signed [NBW-1:0] nz_s, plane_s, off_x, off_y, off_z, nb;
    logic [NBW-1:0] nb_u;
    logic nb_ok;

    always_comb
    begin
        dx = TAP_DX[tap_cnt_reg];
        dy = TAP_DY[tap_cnt_reg];
        dz = TAP_DZ[tap_cnt_reg];
        nz_s    = $signed({{(NBW-7){1'b0}}, nz_reg});
        plane_s = $signed({{(NBW-14){1'b0}}, plane_reg});
        off_x = (dx == STEP_P) ? plane_s : (dx == STEP_M) ? -plane_s : '0;
        off_y = (dy == STEP_P) ? nz_s : (dy == STEP_M) ? -nz_s : '0;
        off_z = (dz == STEP_P) ? NBW'(1) : (dz == STEP_M) ? -NBW'(1) : '0;
        nb    = $signed(NBW'(cell_reg)) + off_x + off_y + off_z;
        nb_u  = unsigned'(nb);
        nb_ok = !nb[NBW-1] && (nb_u < NBW'(GRID_CELLS));
    end

    // memories
    logic            vram_we;
    logic [VAW-1:0]  vram_waddr;
    logic [31:0]     vram_wdata, vram_rdata;
    logic            wram_we;
    logic [WAW-1:0]  wram_waddr;
    logic [31:0]     wram_rdata;

    assign vram_we    = (state_reg == S_CLEAR) ||
                        (req_acc && (req_data.req_type == REQ_WRITE_VOLTAGE) && cell_ok);
    assign vram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : VAW'(req_data.cell_index);
    assign vram_wdata = (state_reg == S_CLEAR) ? 32'd0 : req_data.value;
    assign wram_we    = req_acc && (req_data.req_type == REQ_WRITE_WEIGHT) && cell_ok && tap_ok;
    assign wram_waddr = wbase + WAW'(req_data.tap);

    s19da_ram #(.WIDTH(32), .DEPTH(GRID_CELLS)) u_voltage_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (nb_u[VAW-1:0]),
        .rdata (vram_rdata)
    );

    s19da_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (req_data.value),
        .raddr (waddr_reg),
        .rdata (wram_rdata)
    );

    // shared multiplier: signed products for the taps, unsigned halves for scaling
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb
    begin
        if (state_reg == S_MLO)
        begin
            mul_a = $signed({1'b0, m_reg[31:0]});
            mul_b = $signed({1'b0, s_reg});
        end
        else if (state_reg == S_MHI)
        begin
            mul_a = $signed({1'b0, m_reg[63:32]});
            mul_b = $signed({1'b0, s_reg});
        end
        else
        begin
            mul_a = $signed({wram_rdata[31], wram_rdata});
            mul_b = $signed({vram_rdata[31], vram_rdata});
        end
        mul_p = mul_a * mul_b;
    end

    // saturating accumulate
    logic signed [63:0] acc_sum, acc_sat;
    logic acc_ovf;

    always_comb
    begin
        acc_sum = acc_reg + prod_reg;
        acc_ovf = (acc_reg[63] == prod_reg[63]) && (acc_sum[63] != acc_reg[63]);
        if (!acc_ovf)
        begin
            acc_sat = acc_sum;
        end
        else if (prod_reg[63])
        begin
            acc_sat = {1'b1, 63'd0};
        end
        else
        begin
            acc_sat = {1'b0, {63{1'b1}}};
        end
    end

    // final rounding and saturation
    logic [63:0] q_up;
    logic [31:0] deriv;

    always_comb
    begin
        q_up = q_reg + 64'(rnz_reg);
        if (neg_reg)
        begin
            deriv = (q_up >= 64'h0000_0000_8000_0000) ? 32'h8000_0000 : 32'(-q_up[31:0]);
        end
        else
        begin
            deriv = (q_reg > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q_reg[31:0];
        end
    end

    assign res_load = (state_reg == S_FIN) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == VAW'(GRID_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = cell_ok ? S_READ : S_FIN;
                end
            end
            S_READ:
            begin
                if (tap_cnt_reg == TAP_W'(TAPS - 1))
                begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2: state_next = S_MAG;
            S_MAG:    state_next = S_MLO;
            S_MLO:    state_next = S_MHI;
            S_MHI:    state_next = S_SUM;
            S_SUM:    state_next = S_FIN;
            S_FIN:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            tap_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            scale_reg     <= SCALE_RESET;
            ny_reg        <= NY_RESET;
            nz_reg        <= NZ_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            s1_valid_reg  <= (state_reg == S_READ) && nb_ok;
            s2_valid_reg  <= s1_valid_reg;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + VAW'(1);
            end
            if (start)
            begin
                tap_cnt_reg <= '0;
            end
            else if (state_reg == S_READ)
            begin
                tap_cnt_reg <= tap_cnt_reg + TAP_W'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCALE: scale_reg <= cfg_data;
                    CFG_NY:    ny_reg    <= cfg_data[6:0];
                    CFG_NZ:    nz_reg    <= cfg_data[6:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg <= 14'(ny_reg) * 14'(nz_reg);
        prod_reg  <= mul_p[63:0];
        if (start)
        begin
            cell_reg  <= req_data.cell_index;
            waddr_reg <= wbase;
            bad_reg   <= !cell_ok;
            err_reg   <= !cell_ok;
            acc_reg   <= '0;
        end
        else
        begin
            if (state_reg == S_READ)
            begin
                waddr_reg <= waddr_reg + WAW'(1);
                if (!nb_ok)
                begin
                    err_reg <= 1'b1;
                end
            end
            if (s2_valid_reg)
            begin
                acc_reg <= acc_sat;
            end
        end
        if (state_reg == S_MAG)
        begin
            m_reg   <= acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
            s_reg   <= scale_reg[31] ? 32'(-scale_reg) : 32'(scale_reg);
            neg_reg <= !(acc_reg[63] ^ scale_reg[31]);
        end
        if (state_reg == S_MHI)
        begin
            lo_reg <= prod_reg;
        end
        if (state_reg == S_SUM)
        begin
            // hi partial plus the carry-in half of lo
            q_reg   <= 64'(prod_reg) + {32'd0, lo_reg[63:32]};
            rnz_reg <= |lo_reg[31:0];
        end
        if (res_load)
        begin
            res_reg.derivative  <= bad_reg ? 32'sd0 : $signed(deriv);
            res_reg.range_error <= err_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // checks
    a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
        start && cell_ok |=> state_reg == S_READ)
        else $error("compute start did not enter the tap loop");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> 32'(tap_cnt_reg) < 32'(TAPS))
        else $error("tap counter out of range");

    a_s1_source: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg == S_READ))
        else $error("tap read valid outside the tap loop");

endmodule
